// ===== rtl/linear_contrast_stretch_unit_assert.svh =====
// ----------------------------------------------------------------------------
// linear contrast stretch unit assertion macros
// shared property wrappers, clocked on clk_i and disabled during reset
// ----------------------------------------------------------------------------
`ifndef LINEAR_CONTRAST_STRETCH_UNIT_ASSERT_SVH
`define LINEAR_CONTRAST_STRETCH_UNIT_ASSERT_SVH

// same-cycle implication
`define LCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lcs same-cycle check failed");

// next-cycle implication
`define LCS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lcs next-cycle check failed");

`endif

// ===== rtl/lcs_pkg.sv =====
// ----------------------------------------------------------------------------
// lcs_pkg
// shared types and constants of the linear contrast stretch unit
// ----------------------------------------------------------------------------
package lcs_pkg;

  // full-scale gray level, low byte seeds the running minimum
  localparam int unsigned PixelMax = 255;
  localparam logic [7:0] StatMinReset = 8'(PixelMax);

  // job field widths
  localparam int unsigned NumW  = 21;
  localparam int unsigned SpanW = 10;
  localparam int unsigned QuoW  = 8;
  localparam int unsigned CntW  = $clog2(QuoW);

  typedef enum logic [1:0] {
    CmdClear   = 2'd0,
    CmdMeasure = 2'd1,
    CmdMap     = 2'd2
  } lcs_cmd_e;

  // configuration register indexes
  localparam logic [1:0] RegOutHigh = 2'd0;
  localparam logic [1:0] RegOutLow  = 2'd1;
  localparam logic [1:0] RegInHigh  = 2'd2;
  localparam logic [1:0] RegInLow   = 2'd3;

  // input bound code that selects the measured statistic
  localparam logic signed [8:0] BoundAuto = -9'sd1;

  typedef struct packed {
    logic [7:0]        out_high;
    logic [7:0]        out_low;
    logic signed [8:0] in_high;
    logic signed [8:0] in_low;
  } lcs_cfg_t;

  // one map job between front and back
  typedef struct packed {
    logic                    direct;      // equal bounds, result known
    logic [7:0]              direct_val;
    logic signed [NumW-1:0]  num;         // 2*(uh-ul)*(p-tl) + (2*ul+1)*d
    logic signed [SpanW-1:0] span;        // d = hi - lo
  } lcs_job_t;

endpackage

// ===== rtl/linear_contrast_stretch_unit.sv =====
// ----------------------------------------------------------------------------
// linear_contrast_stretch_unit
// min/max contrast stretch of 8-bit gray pixels with clamped output levels
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       sink       in_valid_i/in_stall_o    command_i, pixel_in_i
//  out      source     out_valid_o/out_stall_i  pixel_out_o
//  cfg      sink       cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
//  clear and measure transactions pass through the front and give no result
//  a map transaction passes the front stages (bounds, then the two products),
//  then the back: pop, magnitude/range check, eight restoring divide steps,
//  clamp; the serial divider finishes one map before it takes the next, and
//  skips the divide steps when bounds are equal or the quotient magnitude passes 255
//  reset clears the statistics (max 0, min 255), the queue, the stage valids
//  and the output valid, and loads the register reset values
//  a stall on the out channel holds the result register; the queue keeps
//  the front taking transactions until it fills
// ----------------------------------------------------------------------------
`include "linear_contrast_stretch_unit_assert.svh"

module linear_contrast_stretch_unit
  import lcs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // pixel commands
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  logic [7:0] pixel_in_i,
  // mapped pixels
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] pixel_out_o,
  // register writes
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [8:0] cfg_data_i
);

  lcs_cfg_t cfg_q;
  logic     cfg_we;

  // queue handshake between front and back
  logic     q_push, q_pop, q_full, q_empty;
  lcs_job_t q_wdata, q_rdata;

  // writes land at any time; the host is to write only while the unit is idle, which the block does not enforce
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.out_high <= 8'd255;
      cfg_q.out_low  <= 8'd0;
      cfg_q.in_high  <= BoundAuto;
      cfg_q.in_low   <= BoundAuto;
    end else if (cfg_we) begin
      case (cfg_index_i)
        RegOutHigh: cfg_q.out_high <= cfg_data_i[7:0];
        RegOutLow:  cfg_q.out_low  <= cfg_data_i[7:0];
        RegInHigh:  cfg_q.in_high  <= $signed(cfg_data_i);
        RegInLow:   cfg_q.in_low   <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // front: statistics and job setup
  lcs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .pixel_in_i (pixel_in_i),
    .push_o     (q_push),
    .job_o      (q_wdata),
    .full_i     (q_full)
  );

  // decoupling queue
  lcs_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  // back: divide, round, clamp
  lcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .job_i       (q_rdata),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_out_o (pixel_out_o)
  );

  // queue never written when full or read when empty
  `LCS_ASSERT_IMP(a_queue_no_overflow, q_push, !q_full)
  `LCS_ASSERT_IMP(a_queue_no_underflow, q_pop, !q_empty)
  // the back works on one job before taking another
  `LCS_ASSERT_NXT(a_back_single_job, q_pop, !q_pop)

endmodule

// ===== rtl/lcs_fifo.sv =====
// ----------------------------------------------------------------------------
// lcs_fifo
// small job queue between the front and the back
// ----------------------------------------------------------------------------
module lcs_fifo
  import lcs_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  lcs_job_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output lcs_job_t data_o,
  output logic     empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW2 = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW2-1:0] FullCnt = CntW2'(Depth);

  lcs_job_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW2-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/lcs_front.sv =====
// ----------------------------------------------------------------------------
// lcs_front
// accepts commands, keeps running min/max, builds map jobs in two stages
// ----------------------------------------------------------------------------
module lcs_front
  import lcs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lcs_cfg_t   cfg_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  logic [7:0] pixel_in_i,
  output logic       push_o,
  output lcs_job_t   job_o,
  input  logic       full_i
);

  logic [7:0] max_q, min_q;

  // stage a: resolved bounds and differences
  logic                    a_valid_q;
  logic                    a_direct_q;
  logic [7:0]              a_dval_q;
  logic signed [8:0]       a_dh_q;
  logic signed [9:0]       a_pt_q;
  logic signed [9:0]       a_m2_q;
  logic signed [SpanW-1:0] a_span_q;

  // stage b: products
  logic                    b_valid_q;
  logic                    b_direct_q;
  logic [7:0]              b_dval_q;
  logic signed [18:0]      b_p1_q;
  logic signed [19:0]      b_p2_q;
  logic signed [SpanW-1:0] b_span_q;

  logic                    accept, a_adv, b_free;
  logic signed [8:0]       th, tl;
  logic signed [SpanW-1:0] span;
  logic signed [9:0]       pt;
  logic signed [8:0]       dh;
  logic signed [18:0]      p1;
  logic signed [19:0]      p2;

  assign push_o     = b_valid_q && !full_i;
  assign b_free     = !b_valid_q || push_o;
  assign a_adv      = a_valid_q && b_free;
  assign in_stall_o = a_valid_q && !a_adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    th   = (cfg_i.in_high == BoundAuto) ? $signed({1'b0, max_q}) : cfg_i.in_high;
    tl   = (cfg_i.in_low == BoundAuto) ? $signed({1'b0, min_q}) : cfg_i.in_low;
    span = $signed({th[8], th}) - $signed({tl[8], tl});
    pt   = $signed({2'b00, pixel_in_i}) - $signed({tl[8], tl});
    dh   = $signed({1'b0, cfg_i.out_high}) - $signed({1'b0, cfg_i.out_low});
    p1   = $signed({{10{a_dh_q[8]}}, a_dh_q}) * $signed({{9{a_pt_q[9]}}, a_pt_q});
    p2   = $signed({{10{a_m2_q[9]}}, a_m2_q}) * $signed({{10{a_span_q[9]}}, a_span_q});
  end

  always_comb begin
    job_o.direct     = b_direct_q;
    job_o.direct_val = b_dval_q;
    job_o.num        = $signed({b_p1_q[18], b_p1_q, 1'b0}) + $signed({b_p2_q[19], b_p2_q});
    job_o.span       = b_span_q;
  end

  // running statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
      min_q <= StatMinReset;
    end else if (accept) begin
      case (lcs_cmd_e'(command_i))
        CmdClear: begin
          max_q <= '0;
          min_q <= StatMinReset;
        end
        CmdMeasure: begin
          if (pixel_in_i > max_q) max_q <= pixel_in_i;
          if (pixel_in_i < min_q) min_q <= pixel_in_i;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (accept && (command_i == CmdMap)) begin
        a_valid_q <= 1'b1;
      end else if (a_adv) begin
        a_valid_q <= 1'b0;
      end
      if (a_adv) begin
        b_valid_q <= 1'b1;
      end else if (push_o) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_direct_q <= (span == '0);
      a_dval_q   <= (pt > 0) ? cfg_i.out_high : cfg_i.out_low;
      a_dh_q     <= dh;
      a_pt_q     <= pt;
      a_m2_q     <= $signed({1'b0, cfg_i.out_low, 1'b1});
      a_span_q   <= span;
    end
    if (a_adv) begin
      b_direct_q <= a_direct_q;
      b_dval_q   <= a_dval_q;
      b_p1_q     <= p1;
      b_p2_q     <= p2;
      b_span_q   <= a_span_q;
    end
  end

endmodule

// ===== rtl/lcs_back.sv =====
// ----------------------------------------------------------------------------
// lcs_back
// serial divider, rounding and clamp, output register
// ----------------------------------------------------------------------------
module lcs_back
  import lcs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lcs_cfg_t   cfg_i,
  input  logic       empty_i,
  output logic       pop_o,
  input  lcs_job_t   job_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] pixel_out_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StCalc = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  logic [1:0]      state_q, state_d;
  lcs_job_t        job_q;
  logic [9:0]      rem_q, den_q;
  logic [7:0]      low_q;
  logic [QuoW-1:0] quo_q;
  logic            neg_q;
  logic [CntW-1:0] cnt_q;
  logic            out_valid_q;
  logic [7:0]      out_q;

  logic [NumW-1:0]  num_neg;
  logic [19:0]      anum;
  logic [SpanW-1:0] span_neg;
  logic [8:0]       aspan;
  logic             sat;
  logic [10:0]      trial;
  logic             take;
  logic signed [9:0] w;
  logic [7:0]       res;
  logic             out_free, fin_go;

  assign pop_o       = (state_q == StIdle) && !empty_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign fin_go      = (state_q == StFin) && out_free;
  assign out_valid_o = out_valid_q;
  assign pixel_out_o = out_q;

  // magnitudes and quotient range check
  always_comb begin
    num_neg  = -job_q.num;
    anum     = job_q.num[NumW-1] ? num_neg[19:0] : job_q.num[19:0];
    span_neg = -job_q.span;
    aspan    = job_q.span[SpanW-1] ? span_neg[8:0] : job_q.span[8:0];
    sat      = anum >= {2'b00, aspan, 9'b0};
  end

  // one restoring step
  always_comb begin
    trial = {rem_q, low_q[7]};
    take  = trial >= {1'b0, den_q};
  end

  // sign, then clamp high before low
  always_comb begin
    w = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
    if (job_q.direct) begin
      res = job_q.direct_val;
    end else if (sat) begin
      res = neg_q ? cfg_i.out_low : cfg_i.out_high;
    end else if (w > $signed({2'b00, cfg_i.out_high})) begin
      res = cfg_i.out_high;
    end else if (w < $signed({2'b00, cfg_i.out_low})) begin
      res = cfg_i.out_low;
    end else begin
      res = w[7:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (pop_o) state_d = StCalc;
      StCalc: state_d = (job_q.direct || sat) ? StFin : StDiv;
      StDiv:  if (cnt_q == '0) state_d = StFin;
      StFin:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    case (state_q)
      StCalc: begin
        rem_q <= anum[17:8];
        low_q <= anum[7:0];
        den_q <= {aspan, 1'b0};
        neg_q <= job_q.num[NumW-1] ^ job_q.span[SpanW-1];
        quo_q <= '0;
        cnt_q <= CntW'(QuoW - 1);
      end
      StDiv: begin
        rem_q <= take ? 10'(trial - {1'b0, den_q}) : trial[9:0];
        quo_q <= {quo_q[QuoW-2:0], take};
        low_q <= {low_q[6:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
      end
      default: ;
    endcase
    if (fin_go) begin
      out_q <= res;
    end
  end

endmodule

// ===== tb/sv/tb_linear_contrast_stretch_unit.sv =====
// ----------------------------------------------------------------------------
// tb_linear_contrast_stretch_unit
// self-checking bench for the min/max contrast stretch unit: a scoreboard
// class tracks registers and running statistics, predicts every mapped
// pixel and checks results in order under random gaps and back-pressure
// ----------------------------------------------------------------------------
module tb_linear_contrast_stretch_unit;
  import lcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // command code the block ignores
  localparam logic [1:0] CmdUnused = 2'd3;

  // cycles to let in-flight clear/measure work settle before a register write
  localparam int unsigned DrainCycles = 40;
  // generous bound on the whole run
  localparam int unsigned CycleLimit  = 200000;
  // long receiver hold-off used to fill the block
  localparam int unsigned HoldCycles  = 400;

  typedef enum logic [1:0] {
    StallNone,
    StallLight,
    StallHeavy,
    StallToggle
  } stall_mode_e;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of registers and statistics, queue of mapped pixels
  // --------------------------------------------------------------------------
  class stretch_scoreboard;
    logic [7:0]        out_high;
    logic [7:0]        out_low;
    logic signed [8:0] in_high;
    logic signed [8:0] in_low;
    logic [7:0]        seen_max;
    logic [7:0]        seen_min;
    logic [7:0]        mapped_pixels[$];
    int unsigned       errors;

    function new();
      out_high = 8'd255;
      out_low  = 8'd0;
      in_high  = BoundAuto;
      in_low   = BoundAuto;
      seen_max = 8'd0;
      seen_min = StatMinReset;
      errors   = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [8:0] data);
      case (idx)
        RegOutHigh: out_high = data[7:0];
        RegOutLow:  out_low  = data[7:0];
        RegInHigh:  in_high  = data;
        RegInLow:   in_low   = data;
        default: ;
      endcase
    endfunction

    // exact integer form of the rounded linear stretch, then the clamp
    function logic [7:0] stretch_pixel(logic [7:0] p);
      longint uh, ul, th, tl, pv, d, num, den, q;
      uh = out_high;
      ul = out_low;
      th = in_high;
      tl = in_low;
      pv = p;
      if (in_high == BoundAuto) th = seen_max;
      if (in_low == BoundAuto) tl = seen_min;
      d = th - tl;
      // equal bounds pick one of the two levels
      if (d == 0) return (pv > tl) ? out_high : out_low;
      num = 2 * (uh - ul) * (pv - tl) + (2 * ul + 1) * d;
      den = 2 * d;
      if (den < 0) begin
        den = -den;
        num = -num;
      end
      if (num >= 0) q = num / den;
      else q = -((-num) / den);
      // upper clamp wins when the output levels are crossed
      if (q > uh) return out_high;
      if (q < ul) return out_low;
      return q[7:0];
    endfunction

    function void note_command(logic [1:0] cmd, logic [7:0] p);
      case (cmd)
        CmdClear: begin
          seen_max = 8'd0;
          seen_min = StatMinReset;
        end
        CmdMeasure: begin
          if (p > seen_max) seen_max = p;
          if (p < seen_min) seen_min = p;
        end
        CmdMap: mapped_pixels.push_back(stretch_pixel(p));
        default: ;
      endcase
    endfunction

    function void check_pixel(logic [7:0] actual);
      logic [7:0] want;
      if (mapped_pixels.size() == 0) begin
        $display("%0t: unexpected pixel_out, expected none, actual %0d", $time, actual);
        errors++;
      end else begin
        want = mapped_pixels.pop_front();
        if (want !== actual) begin
          $display("%0t: pixel_out mismatch, expected %0d, actual %0d",
                   $time, want, actual);
          errors++;
        end
      end
    endfunction

    function int pending();
      return mapped_pixels.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals, inputs driven to known values from time zero
  // --------------------------------------------------------------------------
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [1:0] command_i   = CmdClear;
  logic [7:0] pixel_in_i  = 8'd0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] pixel_out_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = RegOutHigh;
  logic [8:0] cfg_data_i  = 9'd0;

  stretch_scoreboard sb;

  // sender burst bookkeeping
  int unsigned burst_left = 0;
  // receiver stall pattern and the long hold-off request
  stall_mode_e stall_mode = StallNone;
  int unsigned mode_left  = 0;
  int unsigned hold_left  = 0;
  bit          hold_request = 1'b0;
  int unsigned cycle_count = 0;

  linear_contrast_stretch_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .pixel_in_i  (pixel_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_out_o (pixel_out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 4 ns clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // receiver: check each result transaction, then pick the next stall value
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_pixel(pixel_out_o);
    // long hold-off so the block fills up and stalls its input
    if (hold_request) begin
      hold_left = HoldCycles;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      case (stall_mode)
        StallNone:   out_stall_i <= 1'b0;
        StallLight:  out_stall_i <= ($urandom_range(0, 3) == 0);
        StallHeavy:  out_stall_i <= ($urandom_range(0, 3) != 0);
        StallToggle: out_stall_i <= ~out_stall_i;
        default:     out_stall_i <= 1'b0;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // watchdog
  // --------------------------------------------------------------------------
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, sb.pending());
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // driving tasks
  // --------------------------------------------------------------------------

  // one input transaction; returns at the edge that accepts it
  task automatic send_command(input logic [1:0] cmd, input logic [7:0] pix);
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    pixel_in_i <= pix;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_command(cmd, pix);
  endtask

  // drop valid, with junk on the payload, for the requested idle time
  task automatic idle_input(input int unsigned cycles);
    in_valid_i <= 1'b0;
    command_i  <= 2'($urandom_range(0, 3));
    pixel_in_i <= 8'($urandom_range(0, 255));
    repeat (cycles) @(posedge clk_i);
  endtask

  // sender in bursts: a random gap opens each new burst
  task automatic offer(input logic [1:0] cmd, input logic [7:0] pix);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) idle_input(gap);
      // mostly short bursts, sometimes long stretches with no gaps
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    send_command(cmd, pix);
    burst_left--;
  endtask

  // stop sending, wait out every result, then let the front go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // write all four registers back to back; valid stays high across them
  task automatic write_regs(input logic [7:0] oh, input logic [7:0] ol,
                            input logic [8:0] ih, input logic [8:0] il);
    logic [1:0] idx[4];
    logic [8:0] val[4];
    idx = '{RegOutHigh, RegOutLow, RegInHigh, RegInLow};
    // unused top bit of the 8-bit registers toggled at random
    val = '{{1'($urandom_range(0, 1)), oh}, {1'($urandom_range(0, 1)), ol}, ih, il};
    cfg_valid_i <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly clear/measure/map sequences, the rest loose commands
  task automatic run_traffic(input int unsigned items);
    int unsigned sent;
    int unsigned reps;
    logic [1:0]  cmd;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 1) == 0) begin
          offer(CmdClear, pick_pixel());
          sent++;
        end
        reps = $urandom_range(1, 8);
        repeat (reps) offer(CmdMeasure, pick_pixel());
        sent += reps;
        reps = $urandom_range(1, 6);
        repeat (reps) offer(CmdMap, pick_pixel());
        sent += reps;
      end else begin
        cmd = 2'($urandom_range(0, 3));
        offer(cmd, pick_pixel());
        if (cmd != CmdUnused) sent++;
      end
    end
  endtask

  task automatic run_phase(input logic [7:0] oh, input logic [7:0] ol,
                           input logic [8:0] ih, input logic [8:0] il,
                           input int unsigned items, input bit hold_off);
    settle();
    write_regs(oh, ol, ih, il);
    if (hold_off) hold_request = 1'b1;
    run_traffic(items);
  endtask

  // bounds: measured statistic, a pixel level, or any 9-bit value
  function automatic logic [8:0] pick_bound();
    case ($urandom_range(0, 2))
      0: return BoundAuto;
      1: return 9'($urandom_range(0, 255));
      default: return 9'($urandom_range(0, 511));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset register values
    // empty statistics: max 0, min 255, so the span is negative
    offer(CmdMap, 8'd0);
    offer(CmdMap, 8'd255);
    offer(CmdMap, 8'd128);
    offer(CmdUnused, 8'd255);
    // single measured pixel gives equal bounds
    offer(CmdMeasure, 8'd100);
    offer(CmdMap, 8'd100);
    offer(CmdMap, 8'd101);
    offer(CmdMap, 8'd0);
    // full range measured
    offer(CmdMeasure, 8'd0);
    offer(CmdMeasure, 8'd255);
    offer(CmdMap, 8'd0);
    offer(CmdMap, 8'd255);
    offer(CmdMap, 8'd127);
    offer(CmdMap, 8'd200);
    // narrow range, pixels outside it hit the clamps
    offer(CmdClear, 8'd255);
    offer(CmdMeasure, 8'd50);
    offer(CmdMeasure, 8'd60);
    offer(CmdMap, 8'd55);
    offer(CmdMap, 8'd255);
    offer(CmdMap, 8'd0);
    offer(CmdUnused, 8'd0);
    offer(CmdMap, 8'd60);

    // fixed settings: crossed levels, explicit and negative bounds, equal bounds
    run_phase(8'd0,   8'd255, BoundAuto, BoundAuto, 30, 1'b0);
    run_phase(8'd200, 8'd50,  9'sd255,   9'sd0,     30, 1'b1);
    run_phase(8'd255, 8'd0,   -9'sd256,  9'sd255,   25, 1'b0);
    run_phase(8'd128, 8'd128, 9'sd100,   9'sd100,   20, 1'b0);
    run_phase(8'd255, 8'd0,   BoundAuto, 9'sd0,     25, 1'b0);
    run_phase(8'd10,  8'd245, -9'sd2,    BoundAuto, 25, 1'b0);
    run_phase(8'd255, 8'd0,   9'sd0,     9'sd255,   25, 1'b0);

    // random settings
    repeat (7) begin
      run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                pick_bound(), pick_bound(), 25, 1'b0);
    end

    // back to reset values
    run_phase(8'd255, 8'd0, BoundAuto, BoundAuto, 15, 1'b0);

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lcs_pkg.sv
rtl/lcs_fifo.sv
rtl/lcs_front.sv
rtl/lcs_back.sv
rtl/linear_contrast_stretch_unit.sv
tb/sv/tb_linear_contrast_stretch_unit.sv
